[rtl/ffba_pkg.sv]
// Types and codes shared by the first-fit block allocator.
// No dependencies.
package ffba_pkg;

  localparam int REQ_W = 21;
  localparam int OFS_W = 20;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_FIT  = 3'd1,
    ST_FULL    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_NULL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_NULL
  } op_t;

  typedef struct packed {
    logic             command;
    logic [REQ_W-1:0] request_bytes;
    logic [OFS_W-1:0] payload_offset;
  } cmd_t;

  typedef struct packed {
    status_t          status;
    logic [OFS_W-1:0] result_offset;
  } rsp_t;

  typedef struct packed {
    op_t              op;
    logic [REQ_W-1:0] req;
    logic [OFS_W-1:0] ptr;
  } job_t;

  typedef struct packed {
    logic [OFS_W-1:0] start;
    logic [OFS_W-1:0] length;
    logic             free;
  } entry_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_NEXT_RD,
    S_NEXT_CHK,
    S_SHIFT,
    S_W_NEW,
    S_W_CUR,
    S_DONE
  } state_t;

endpackage

[rtl/ffba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/ffba_front.sv]
// Front end: accepts command items, classifies them and queues them.
// Depends on ffba_pkg.
module ffba_front import ffba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic q_valid,
  input  logic q_pop,
  output job_t q_job
);

  job_t        slot [2];
  logic        wp;
  logic        rp;
  logic [1:0]  fill;
  logic        push;
  logic        pop;
  job_t        job_in;

  assign cmd_stall = (fill == 2'd2);
  assign push      = cmd_valid && !cmd_stall;
  assign q_valid   = (fill != 2'd0);
  assign pop       = q_pop && q_valid;
  assign q_job     = slot[rp];

  always_comb begin
    job_in.req = cmd.request_bytes;
    job_in.ptr = cmd.payload_offset;
    if (!cmd.command) begin
      job_in.op = OP_ALLOC;
    end else if (cmd.payload_offset == '0) begin
      job_in.op = OP_NULL;
    end else begin
      job_in.op = OP_FREE;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= job_in;
    end
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

[rtl/ffba_back.sv]
// Back end: walks the block table, splits, merges and shifts entries.
// Depends on ffba_pkg and ffba_ram.
module ffba_back import ffba_pkg::*; #(
  parameter int HEAP_BYTES   = 1048576,
  parameter int HEADER_BYTES = 12,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_pop,
  input  job_t q_job,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  state_t           state, state_next;
  logic [CW-1:0]    cnt, cnt_next;
  job_t             job, job_next;
  logic [CW-1:0]    scan_idx, scan_idx_next;
  logic             rd_v, rd_v_next;
  logic [IW-1:0]    rd_idx, rd_idx_next;
  logic [IW-1:0]    hit_idx, hit_idx_next;
  entry_t           hit_e, hit_e_next;
  entry_t           new_e, new_e_next;
  logic [OFS_W-1:0] cur_len, cur_len_next;
  logic             cur_free, cur_free_next;
  logic             cnt_inc, cnt_inc_next;
  logic             cnt_dec, cnt_dec_next;
  logic [IW-1:0]    sh_src, sh_src_next;
  logic [IW-1:0]    sh_end, sh_end_next;
  logic             sh_up, sh_up_next;
  logic             sh_go, sh_go_next;
  rsp_t             res, res_next;
  logic             rsp_valid_next;
  rsp_t             rsp_next;

  logic             we;
  logic [IW-1:0]    waddr;
  entry_t           wdata;
  logic [IW-1:0]    raddr;
  entry_t           rdata;

  logic             fit;
  logic             split;
  logic             match;
  logic             hit;

  ffba_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_BLOCKS)) u_tab (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign fit   = rdata.free && ({1'b0, rdata.length} >= job.req);
  assign split = {2'b00, rdata.length} > ({1'b0, job.req} + 22'(HEADER_BYTES));
  assign match = ({1'b0, rdata.start} + 21'(HEADER_BYTES)) == {1'b0, job.ptr};
  assign hit   = rd_v && ((job.op == OP_ALLOC) ? fit : match);

  always_ff @(posedge clk) begin
    job      <= job_next;
    scan_idx <= scan_idx_next;
    rd_idx   <= rd_idx_next;
    hit_idx  <= hit_idx_next;
    hit_e    <= hit_e_next;
    new_e    <= new_e_next;
    cur_len  <= cur_len_next;
    cur_free <= cur_free_next;
    cnt_inc  <= cnt_inc_next;
    cnt_dec  <= cnt_dec_next;
    sh_src   <= sh_src_next;
    sh_end   <= sh_end_next;
    sh_up    <= sh_up_next;
    res      <= res_next;
    rsp      <= rsp_next;
    if (rst) begin
      state     <= S_INIT;
      cnt       <= CW'(1);
      rd_v      <= 1'b0;
      sh_go     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      rd_v      <= rd_v_next;
      sh_go     <= sh_go_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    job_next       = job;
    scan_idx_next  = scan_idx;
    rd_v_next      = 1'b0;
    rd_idx_next    = rd_idx;
    hit_idx_next   = hit_idx;
    hit_e_next     = hit_e;
    new_e_next     = new_e;
    cur_len_next   = cur_len;
    cur_free_next  = cur_free;
    cnt_inc_next   = cnt_inc;
    cnt_dec_next   = cnt_dec;
    sh_src_next    = sh_src;
    sh_end_next    = sh_end;
    sh_up_next     = sh_up;
    sh_go_next     = sh_go;
    res_next       = res;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    q_pop          = 1'b0;
    we             = 1'b0;
    waddr          = hit_idx;
    wdata          = '{start: hit_e.start, length: cur_len, free: cur_free};
    raddr          = scan_idx[IW-1:0];

    unique case (state)
      S_INIT: begin
        we          = 1'b1;
        waddr       = '0;
        wdata.start  = '0;
        wdata.length = OFS_W'(HEAP_BYTES - HEADER_BYTES);
        wdata.free   = 1'b1;
        state_next  = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          job_next      = q_job;
          scan_idx_next = '0;
          cnt_inc_next  = 1'b0;
          cnt_dec_next  = 1'b0;
          if (q_job.op == OP_NULL) begin
            res_next   = '{status: ST_NULL, result_offset: '0};
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          hit_idx_next = rd_idx;
          hit_e_next   = rdata;
          if (job.op == OP_ALLOC) begin
            res_next = '{status: ST_OK,
                         result_offset: OFS_W'(rdata.start + OFS_W'(HEADER_BYTES))};
            cur_free_next = 1'b0;
            if (split) begin
              if (cnt == CW'(MAX_BLOCKS)) begin
                res_next   = '{status: ST_FULL, result_offset: '0};
                state_next = S_DONE;
              end else begin
                new_e_next.start  = OFS_W'(rdata.start + OFS_W'(HEADER_BYTES)
                                           + OFS_W'(job.req));
                new_e_next.length = OFS_W'(rdata.length - OFS_W'(job.req)
                                           - OFS_W'(HEADER_BYTES));
                new_e_next.free   = 1'b1;
                cur_len_next      = OFS_W'(job.req);
                cnt_inc_next      = 1'b1;
                if ((CW'(rd_idx) + CW'(1)) < cnt) begin
                  sh_up_next  = 1'b1;
                  sh_go_next  = 1'b1;
                  sh_src_next = IW'(cnt - CW'(1));
                  sh_end_next = IW'(rd_idx + IW'(1));
                  state_next  = S_SHIFT;
                end else begin
                  state_next = S_W_NEW;
                end
              end
            end else begin
              cur_len_next = rdata.length;
              state_next   = S_W_CUR;
            end
          end else begin
            res_next      = '{status: ST_OK, result_offset: '0};
            cur_len_next  = rdata.length;
            cur_free_next = 1'b1;
            if ((CW'(rd_idx) + CW'(1)) < cnt) begin
              state_next = S_NEXT_RD;
            end else begin
              state_next = S_W_CUR;
            end
          end
        end else if (scan_idx == cnt) begin
          res_next   = '{status: (job.op == OP_ALLOC) ? ST_NO_FIT : ST_UNKNOWN,
                         result_offset: '0};
          state_next = S_DONE;
        end else begin
          rd_v_next     = 1'b1;
          rd_idx_next   = scan_idx[IW-1:0];
          scan_idx_next = scan_idx + CW'(1);
        end
      end
      S_NEXT_RD: begin
        raddr      = IW'(hit_idx + IW'(1));
        state_next = S_NEXT_CHK;
      end
      S_NEXT_CHK: begin
        if (rdata.free) begin
          cur_len_next = OFS_W'(cur_len + OFS_W'(HEADER_BYTES) + rdata.length);
          cnt_dec_next = 1'b1;
          if ((CW'(hit_idx) + CW'(2)) < cnt) begin
            sh_up_next  = 1'b0;
            sh_go_next  = 1'b1;
            sh_src_next = IW'(hit_idx + IW'(2));
            sh_end_next = IW'(cnt - CW'(1));
            state_next  = S_SHIFT;
          end else begin
            state_next = S_W_CUR;
          end
        end else begin
          state_next = S_W_CUR;
        end
      end
      S_SHIFT: begin
        raddr = sh_src;
        if (sh_go) begin
          rd_v_next   = 1'b1;
          rd_idx_next = sh_src;
          if (sh_src == sh_end) begin
            sh_go_next = 1'b0;
          end else begin
            sh_src_next = sh_up ? IW'(sh_src - IW'(1)) : IW'(sh_src + IW'(1));
          end
        end
        if (rd_v) begin
          we    = 1'b1;
          waddr = sh_up ? IW'(rd_idx + IW'(1)) : IW'(rd_idx - IW'(1));
          wdata = rdata;
        end
        if (!sh_go && !rd_v) begin
          state_next = sh_up ? S_W_NEW : S_W_CUR;
        end
      end
      S_W_NEW: begin
        we         = 1'b1;
        waddr      = IW'(hit_idx + IW'(1));
        wdata      = new_e;
        state_next = S_W_CUR;
      end
      S_W_CUR: begin
        we         = 1'b1;
        cnt_next   = cnt + CW'(cnt_inc) - CW'(cnt_dec);
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next = 1'b1;
          rsp_next       = res;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[rtl/first_fit_block_allocator.sv]
// First-fit block allocator over a byte heap. In its first state after reset the
// back end writes the single free block; items are queued meanwhile. An item
// searches a table of N blocks with one table read per cycle from the block RAM.
// A split or merge then moves only the entries above the hit, one per cycle, before
// the entry write-back. Null frees skip the search. Results come out in order, one per item.
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int HEAP_BYTES   = 1048576,
  parameter int HEADER_BYTES = 12,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic q_valid;
  logic q_pop;
  job_t q_job;

  ffba_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_job     (q_job)
  );

  ffba_back #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_job     (q_job),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

[rtl/ffba_checker.sv]
// Port-level checks for the first-fit block allocator, bound to the top.
// Depends on ffba_pkg and first_fit_block_allocator.
module ffba_checker import ffba_pkg::*; #(
  parameter int HEADER_BYTES = 12
) (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> rsp.result_offset == '0)
    else $error("failed item carries an offset");

  a_ofs_min: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.result_offset != '0) |->
      ({1'b0, rsp.result_offset} >= 21'(HEADER_BYTES)))
    else $error("offset below one header");

endmodule

bind first_fit_block_allocator ffba_checker #(.HEADER_BYTES(HEADER_BYTES)) u_chk (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

[verif/first_fit_block_allocator_test.sv]
// Self-checking testbench for the first-fit block allocator.
// Drives allocate and free items, predicts each result from a table model of its own.
// Depends on ffba_pkg and first_fit_block_allocator.
`timescale 1ns / 1ps

module first_fit_block_allocator_test;
  import ffba_pkg::*;

  localparam int HEAP   = 1048576;
  localparam int HDR    = 12;
  localparam int NBLK   = 64;
  localparam int WDOG   = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  first_fit_block_allocator i_dut (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #10 clk = ~clk;

  // heap table model
  logic [19:0] blk_start [NBLK];
  logic [19:0] blk_len [NBLK];
  logic        blk_free [NBLK];
  int          blk_cnt;

  rsp_t        pending_rsp [$];
  logic [19:0] live_ptrs [$];
  int          errors = 0;
  int          n_items = 0;
  int          n_rsp = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          quiet = 0;
  logic        done_flag = 1'b0;

  function automatic void table_reset();
    for (int i = 0; i < NBLK; i++) begin
      blk_start[i] = '0; blk_len[i] = '0; blk_free[i] = 1'b0;
    end
    blk_len[0] = 20'(HEAP - HDR);
    blk_free[0] = 1'b1;
    blk_cnt = 1;
  endfunction

  function automatic rsp_t heap_predict(cmd_t c);
    rsp_t r;
    logic [21:0] req;
    logic [21:0] len;
    r.status = ST_NO_FIT;
    r.result_offset = '0;
    if (c.command == 1'b0) begin
      req = {1'b0, c.request_bytes};
      for (int i = 0; i < blk_cnt; i++) begin
        len = {2'b0, blk_len[i]};
        if (blk_free[i] && len >= req) begin
          if (len > req + HDR) begin
            if (blk_cnt >= NBLK) begin
              r.status = ST_FULL;
              return r;
            end
            for (int k = blk_cnt; k > i + 1; k--) begin
              blk_start[k] = blk_start[k-1]; blk_len[k] = blk_len[k-1];
              blk_free[k] = blk_free[k-1];
            end
            blk_start[i+1] = 20'(blk_start[i] + HDR + req[19:0]);
            blk_len[i+1] = 20'(len - req - HDR);
            blk_free[i+1] = 1'b1;
            blk_len[i] = req[19:0];
            blk_cnt++;
          end
          blk_free[i] = 1'b0;
          r.status = ST_OK;
          r.result_offset = 20'(blk_start[i] + HDR);
          return r;
        end
      end
      return r;
    end
    if (c.payload_offset == '0) begin
      r.status = ST_NULL;
      return r;
    end
    for (int i = 0; i < blk_cnt; i++) begin
      if ({1'b0, blk_start[i]} + HDR == {1'b0, c.payload_offset}) begin
        blk_free[i] = 1'b1;
        if (i + 1 < blk_cnt && blk_free[i+1]) begin
          blk_len[i] = 20'(blk_len[i] + HDR + blk_len[i+1]);
          for (int k = i + 1; k + 1 < blk_cnt; k++) begin
            blk_start[k] = blk_start[k+1]; blk_len[k] = blk_len[k+1];
            blk_free[k] = blk_free[k+1];
          end
          blk_cnt--;
          blk_start[blk_cnt] = '0; blk_len[blk_cnt] = '0; blk_free[blk_cnt] = 1'b0;
        end
        r.status = ST_OK;
        return r;
      end
    end
    r.status = ST_UNKNOWN;
    return r;
  endfunction

  task automatic send_item(logic c, logic [20:0] req, logic [19:0] ptr);
    cmd_t x;
    logic idle;
    x.command = c; x.request_bytes = req; x.payload_offset = ptr;
    idle = ($urandom_range(99) < send_idle);
    if (idle) cmd_valid <= 1'b0;
    while (idle) begin
      @(posedge clk);
      idle = ($urandom_range(99) < send_idle);
    end
    cmd_valid <= 1'b1;
    cmd <= x;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    pending_rsp.push_back(heap_predict(x));
    n_items++;
    if (c == 1'b0 && pending_rsp[$].status == ST_OK) begin
      live_ptrs.push_back(pending_rsp[$].result_offset);
    end
  endtask

  task automatic send_alloc(logic [20:0] req);
    send_item(1'b0, req, 20'($urandom));
  endtask

  task automatic send_free(logic [19:0] ptr);
    send_item(1'b1, 21'($urandom), ptr);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // response checker and receiver stalls
  always @(posedge clk) begin
    rsp_t e;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        n_rsp++;
        if (pending_rsp.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none, actual %h", $time, rsp);
        end else begin
          e = pending_rsp.pop_front();
          if (rsp.status !== e.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, e.status, rsp.status);
          end
          if (rsp.result_offset !== e.result_offset) begin
            errors++;
            $display("%0t: offset expected %h actual %h", $time, e.result_offset,
                     rsp.result_offset);
          end
        end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst && !done_flag) begin
      if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WDOG) begin
        $display("watchdog expired after %0d idle cycles", quiet);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic test_directed();
    logic [19:0] p;
    send_free(20'd0);
    send_free(20'hFFFFF);
    send_free(20'd5);
    send_alloc(21'd0);
    send_alloc(21'd1);
    send_alloc(21'd100);
    send_alloc(21'd1048576);
    send_alloc(21'h1FFFFF);
    p = live_ptrs[1];
    send_free(p);
    send_free(p);
    send_alloc(21'd1);
    send_free(live_ptrs[0]);
    send_free(live_ptrs[2]);
    send_alloc(21'd13);
    send_alloc(21'd12);
    send_alloc(21'd1048500);
    drain();
  endtask

  task automatic test_table_full();
    for (int i = 0; i < NBLK + 4; i++) send_alloc(21'($urandom_range(0, 64)));
    send_alloc(21'd0);
    drain();
    // pause until all results arrive, then free everything, and free it all again in reverse
    for (int i = 0; i < live_ptrs.size(); i++) send_free(live_ptrs[i]);
    for (int i = live_ptrs.size() - 1; i >= 0; i--) send_free(live_ptrs[i]);
    live_ptrs.delete();
    drain();
  endtask

  task automatic test_random(int count);
    int idx;
    logic [20:0] req;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          case ($urandom_range(9))
            0: req = 21'($urandom);
            1: req = 21'($urandom_range(HEAP - HDR - 2, HEAP + 2));
            2: req = 21'($urandom_range(0, 20000));
            default: req = 21'($urandom_range(0, 4000));
          endcase
          send_alloc(req);
        end
        4, 5, 6, 7: begin
          if (live_ptrs.size() != 0) begin
            idx = $urandom_range(live_ptrs.size() - 1);
            send_free(live_ptrs[idx]);
            live_ptrs.delete(idx);
          end else send_free(20'($urandom));
        end
        8: send_free($urandom_range(0, 1) ? 20'd0 : 20'($urandom));
        default: begin
          if (live_ptrs.size() != 0) send_free(live_ptrs[$urandom_range(live_ptrs.size() - 1)]);
          else send_alloc(21'($urandom_range(0, 64)));
        end
      endcase
    end
    drain();
  endtask

  initial begin
    table_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    send_idle = 12; recv_idle = 80;
    test_directed();
    test_table_full();
    test_random(550);
    send_idle = 80; recv_idle = 12;
    test_random(550);
    send_idle = 0; recv_idle = 0;
    test_random(550);
    drain();
    repeat (2 * NBLK + 20) @(posedge clk);
    done_flag = 1'b1;
    $display("Covered %0d items and %0d results: null, unknown, double free,", n_items, n_rsp);
    $display("splits, merges, table full and no fit under three idle patterns.");
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_rsp.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
